// ----- rtl/mfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the multilevel feedback scheduler
// Sizes, operation and result codes, the FSM state type and the task record.
// ----------------------------------------------------------------------------
package mfs_pkg;

    // Task table sizing
    localparam int MAX_TASKS  = 16;
    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);

    // Queues: ready levels 0..3, then the wait queue
    localparam int NUM_LEVELS = 4;
    localparam int NUM_QUEUES = NUM_LEVELS + 1;
    localparam int QUEUE_W    = $clog2(NUM_QUEUES);

    // Beat field widths
    localparam int OP_W       = 3;
    localparam int LEVEL_W    = 2;
    localparam int ELAPSED_W  = 32;
    localparam int PID_W      = 5;
    localparam int CODE_W     = 2;
    localparam int SVC_W      = 48;
    localparam int CALL_W     = 32;

    localparam logic [QUEUE_W-1:0] PARK_QUEUE   = QUEUE_W'(NUM_LEVELS);
    localparam logic [LEVEL_W-1:0] LOWEST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_DISPATCH  = 3'd1,
        OP_SLICE_END = 3'd2,
        OP_WAIT      = 3'd3,
        OP_TERMINATE = 3'd4
    } t_op;

    typedef enum logic [CODE_W-1:0] {
        RES_OK      = 2'd0,
        RES_NONE    = 2'd1,
        RES_FULL    = 2'd2,
        RES_RUNNING = 2'd3
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Per-task record held in the task RAM
    typedef struct packed {
        logic [LEVEL_W-1:0] desired;
        logic [LEVEL_W-1:0] current;
        logic [SVC_W-1:0]   service;
        logic [CALL_W-1:0]  calls;
    } t_task_rec;

    localparam int TASK_W = $bits(t_task_rec);

endpackage

// ----- rtl/mfs_ifs.sv -----
// ----------------------------------------------------------------------------
// mfs_ifs: request and response channels of the scheduler
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mfs_req_if;
    logic                           valid;
    logic                           ready;
    logic [mfs_pkg::OP_W-1:0]       op;
    logic [mfs_pkg::LEVEL_W-1:0]    priority_req;
    logic [mfs_pkg::ELAPSED_W-1:0]  elapsed_ms;

    modport source (output valid, output op, output priority_req, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input op, input priority_req, input elapsed_ms,
                    output ready);
endinterface

interface mfs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mfs_pkg::PID_W-1:0]      task_pid;
    logic [mfs_pkg::CODE_W-1:0]     result_code;
    logic [mfs_pkg::LEVEL_W-1:0]    task_priority;
    logic [mfs_pkg::SVC_W-1:0]      total_service_ms;
    logic [mfs_pkg::CALL_W-1:0]     slice_count;

    modport source (output valid, output task_pid, output result_code,
                    output task_priority, output total_service_ms,
                    output slice_count, input ready);
    modport sink   (input valid, input task_pid, input result_code,
                    input task_priority, input total_service_ms,
                    input slice_count, output ready);
endinterface

// ----- rtl/mfs_ram.sv -----
// ----------------------------------------------------------------------------
// mfs_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/multilevel_feedback_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_task_scheduler_unit: four-level feedback task scheduler
// Create, dispatch, slice end, wait and terminate over RAM-held task state.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  i_req    in   op, priority_req, elapsed_ms
//  o_rsp    out  task_pid, result_code, task_priority, total_service_ms,
//                slice_count
//
//  Every request is taken in idle, which reads the task RAM and the shared
//  link/free-pid RAM, and finished in exec, which modifies, writes back and
//  loads the output register. Reset is synchronous; RAM contents stay
//  undefined and need no clearing pass. A request is taken in idle while the
//  output register is empty or draining.
// ----------------------------------------------------------------------------
module multilevel_feedback_task_scheduler_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfs_req_if.sink   i_req,
    mfs_rsp_if.source o_rsp
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mfs_pkg::t_state                  r_state, n_state;
    logic [mfs_pkg::OP_W-1:0]         r_op, n_op;
    logic [mfs_pkg::LEVEL_W-1:0]      r_prio, n_prio;
    logic [mfs_pkg::ELAPSED_W-1:0]    r_elapsed, n_elapsed;
    logic [mfs_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic                             r_from_stack, n_from_stack;
    logic [mfs_pkg::QUEUE_W-1:0]      r_pop_q, n_pop_q;
    logic                             r_err, n_err;
    mfs_pkg::t_result                 r_code, n_code;

    logic [mfs_pkg::SLOT_W-1:0]       r_q_head [mfs_pkg::NUM_QUEUES];
    logic [mfs_pkg::SLOT_W-1:0]       n_q_head [mfs_pkg::NUM_QUEUES];
    logic [mfs_pkg::SLOT_W-1:0]       r_q_tail [mfs_pkg::NUM_QUEUES];
    logic [mfs_pkg::SLOT_W-1:0]       n_q_tail [mfs_pkg::NUM_QUEUES];
    logic [mfs_pkg::NUM_QUEUES-1:0]   r_q_nonempty, n_q_nonempty;

    logic [mfs_pkg::SLOT_W-1:0]       r_run_slot, n_run_slot;
    logic                             r_run_valid, n_run_valid;
    logic [mfs_pkg::CNT_W-1:0]        r_fresh_cnt, n_fresh_cnt;
    logic [mfs_pkg::CNT_W-1:0]        r_free_top, n_free_top;

    logic                             r_out_valid, n_out_valid;
    logic [mfs_pkg::PID_W-1:0]        r_out_pid, n_out_pid;
    mfs_pkg::t_result                 r_out_code, n_out_code;
    logic [mfs_pkg::LEVEL_W-1:0]      r_out_prio, n_out_prio;
    logic [mfs_pkg::SVC_W-1:0]        r_out_svc, n_out_svc;
    logic [mfs_pkg::CALL_W-1:0]       r_out_calls, n_out_calls;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic                             task_we;
    logic [mfs_pkg::SLOT_W-1:0]       task_waddr, task_raddr;
    mfs_pkg::t_task_rec               task_wdata, task_rdata;
    logic [mfs_pkg::TASK_W-1:0]       task_rdata_raw;

    logic                             link_we;
    logic [mfs_pkg::SLOT_W-1:0]       link_waddr, link_raddr, link_wdata;

    logic                             stack_we;
    logic [mfs_pkg::SLOT_W-1:0]       stack_waddr, stack_raddr, stack_wdata;

    // links live in the low half, the free-pid stack in the high half
    logic                             list_we;
    logic [mfs_pkg::SLOT_W:0]         list_waddr, list_raddr;
    logic [mfs_pkg::SLOT_W-1:0]       list_wdata, list_rdata;

    mfs_ram #(.WIDTH(mfs_pkg::TASK_W), .DEPTH(mfs_pkg::MAX_TASKS)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (task_wdata),
        .i_raddr (task_raddr),
        .o_rdata (task_rdata_raw)
    );
    assign task_rdata = mfs_pkg::t_task_rec'(task_rdata_raw);

    mfs_ram #(.WIDTH(mfs_pkg::SLOT_W), .DEPTH(2 * mfs_pkg::MAX_TASKS)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    // Stack pushes happen in idle, link writes in exec: never together.
    // Only create reads the stack, only dispatch reads a link.
    assign list_we    = link_we || stack_we;
    assign list_waddr = stack_we ? {1'b1, stack_waddr} : {1'b0, link_waddr};
    assign list_wdata = stack_we ? stack_wdata : link_wdata;
    assign list_raddr = (i_req.op == mfs_pkg::OP_CREATE) ? {1'b1, stack_raddr}
                                                         : {1'b0, link_raddr};

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic accept;
    assign i_req.ready = (r_state == mfs_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.task_pid         = r_out_pid;
    assign o_rsp.result_code      = r_out_code;
    assign o_rsp.task_priority    = r_out_prio;
    assign o_rsp.total_service_ms = r_out_svc;
    assign o_rsp.slice_count      = r_out_calls;

    // ------------------------------------------------------------------
    // Lowest-numbered non-empty ready level (level 0 wins)
    // ------------------------------------------------------------------
    logic                        any_ready;
    logic [mfs_pkg::QUEUE_W-1:0] sel_q;

    always_comb begin
        any_ready = 1'b0;
        sel_q     = '0;
        for (int i = mfs_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_q_nonempty[i]) begin
                any_ready = 1'b1;
                sel_q     = mfs_pkg::QUEUE_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    logic [mfs_pkg::SLOT_W-1:0]    ex_slot;
    logic [mfs_pkg::SVC_W:0]       svc_sum;
    mfs_pkg::t_task_rec            upd_rec;
    logic                          push_en;
    logic [mfs_pkg::QUEUE_W-1:0]   push_q;
    logic [mfs_pkg::CNT_W-1:0]     top_dec;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_prio       = r_prio;
        n_elapsed    = r_elapsed;
        n_slot       = r_slot;
        n_from_stack = r_from_stack;
        n_pop_q      = r_pop_q;
        n_err        = r_err;
        n_code       = r_code;
        n_q_head     = r_q_head;
        n_q_tail     = r_q_tail;
        n_q_nonempty = r_q_nonempty;
        n_run_slot   = r_run_slot;
        n_run_valid  = r_run_valid;
        n_fresh_cnt  = r_fresh_cnt;
        n_free_top   = r_free_top;
        n_out_valid  = r_out_valid;
        n_out_pid    = r_out_pid;
        n_out_code   = r_out_code;
        n_out_prio   = r_out_prio;
        n_out_svc    = r_out_svc;
        n_out_calls  = r_out_calls;

        task_we     = 1'b0;
        task_waddr  = '0;
        task_wdata  = '0;
        task_raddr  = r_run_slot;
        link_we     = 1'b0;
        link_waddr  = '0;
        link_wdata  = '0;
        link_raddr  = r_q_head[sel_q];
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = r_run_slot;
        top_dec     = mfs_pkg::CNT_W'(r_free_top - mfs_pkg::CNT_W'(1));
        stack_raddr = top_dec[mfs_pkg::SLOT_W-1:0];

        ex_slot = r_from_stack ? list_rdata : r_slot;
        svc_sum = {1'b0, task_rdata.service} + mfs_pkg::SVC_W'(r_elapsed) + '0;
        upd_rec = task_rdata;
        push_en = 1'b0;
        push_q  = mfs_pkg::QUEUE_W'(r_prio);

        // output register drains
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // Idle state: decide, reserve resources, issue RAM reads
            mfs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state      = mfs_pkg::ST_EXEC;
                    n_op         = i_req.op;
                    n_prio       = i_req.priority_req;
                    n_elapsed    = i_req.elapsed_ms;
                    n_from_stack = 1'b0;
                    n_err        = 1'b0;
                    n_code       = mfs_pkg::RES_OK;
                    case (i_req.op)
                        mfs_pkg::OP_CREATE: begin
                            if (r_free_top != '0) begin
                                n_from_stack = 1'b1;
                                n_free_top   = top_dec;
                            end else if (r_fresh_cnt < mfs_pkg::CNT_W'(mfs_pkg::MAX_TASKS)) begin
                                n_slot      = r_fresh_cnt[mfs_pkg::SLOT_W-1:0];
                                n_fresh_cnt = mfs_pkg::CNT_W'(r_fresh_cnt + mfs_pkg::CNT_W'(1));
                            end else begin
                                n_err  = 1'b1;
                                n_code = mfs_pkg::RES_FULL;
                            end
                        end
                        mfs_pkg::OP_DISPATCH: begin
                            if (r_run_valid) begin
                                n_err  = 1'b1;
                                n_code = mfs_pkg::RES_RUNNING;
                            end else if (any_ready) begin
                                n_slot      = r_q_head[sel_q];
                                n_pop_q     = sel_q;
                                n_run_slot  = r_q_head[sel_q];
                                n_run_valid = 1'b1;
                                task_raddr  = r_q_head[sel_q];
                            end else begin
                                n_err  = 1'b1;
                                n_code = mfs_pkg::RES_NONE;
                            end
                        end
                        mfs_pkg::OP_SLICE_END, mfs_pkg::OP_WAIT, mfs_pkg::OP_TERMINATE: begin
                            if (!r_run_valid) begin
                                n_err  = 1'b1;
                                n_code = mfs_pkg::RES_NONE;
                            end else begin
                                n_slot      = r_run_slot;
                                n_run_valid = 1'b0;
                                if (i_req.op == mfs_pkg::OP_TERMINATE) begin
                                    // free the pid now: push onto the free stack
                                    stack_we    = 1'b1;
                                    stack_waddr = (r_free_top ==
                                                   mfs_pkg::CNT_W'(mfs_pkg::MAX_TASKS))
                                                  ? '0 : r_free_top[mfs_pkg::SLOT_W-1:0];
                                    if (r_free_top < mfs_pkg::CNT_W'(mfs_pkg::MAX_TASKS)) begin
                                        n_free_top = mfs_pkg::CNT_W'(r_free_top +
                                                                     mfs_pkg::CNT_W'(1));
                                    end
                                end
                            end
                        end
                        default: begin
                            // unknown op: all-zero beat
                            n_err = 1'b1;
                        end
                    endcase
                end
            end

            // Exec state: modify, write back, load the output register
            mfs_pkg::ST_EXEC: begin
                n_state     = mfs_pkg::ST_IDLE;
                n_out_valid = 1'b1;
                n_out_code  = r_code;
                n_out_pid   = '0;
                n_out_prio  = '0;
                n_out_svc   = '0;
                n_out_calls = '0;
                if (!r_err) begin
                    n_out_pid   = mfs_pkg::PID_W'(mfs_pkg::CNT_W'(ex_slot) + mfs_pkg::CNT_W'(1));
                    n_out_prio  = task_rdata.current;
                    n_out_svc   = task_rdata.service;
                    n_out_calls = task_rdata.calls;
                    case (r_op)
                        mfs_pkg::OP_CREATE: begin
                            task_we            = 1'b1;
                            task_waddr         = ex_slot;
                            task_wdata.desired = r_prio;
                            task_wdata.current = r_prio;
                            task_wdata.service = '0;
                            task_wdata.calls   = '0;
                            push_en            = 1'b1;
                            push_q             = mfs_pkg::QUEUE_W'(r_prio);
                            n_out_prio         = r_prio;
                            n_out_svc          = '0;
                            n_out_calls        = '0;
                        end
                        mfs_pkg::OP_DISPATCH: begin
                            // pop the head of the chosen level
                            if (r_slot == r_q_tail[r_pop_q]) begin
                                n_q_nonempty[r_pop_q] = 1'b0;
                            end else begin
                                n_q_head[r_pop_q] = list_rdata;
                            end
                        end
                        mfs_pkg::OP_SLICE_END: begin
                            upd_rec.service = svc_sum[mfs_pkg::SVC_W] ? '1
                                              : svc_sum[mfs_pkg::SVC_W-1:0];
                            if (task_rdata.calls != '1) begin
                                upd_rec.calls = mfs_pkg::CALL_W'(task_rdata.calls + 1'b1);
                            end
                            if (task_rdata.current != mfs_pkg::LOWEST_LEVEL) begin
                                upd_rec.current = mfs_pkg::LEVEL_W'(task_rdata.current + 1'b1);
                            end else begin
                                upd_rec.current = task_rdata.desired;
                            end
                            task_we     = 1'b1;
                            task_waddr  = ex_slot;
                            task_wdata  = upd_rec;
                            push_en     = 1'b1;
                            push_q      = mfs_pkg::QUEUE_W'(upd_rec.current);
                            n_out_prio  = upd_rec.current;
                            n_out_svc   = upd_rec.service;
                            n_out_calls = upd_rec.calls;
                        end
                        mfs_pkg::OP_WAIT: begin
                            push_en = 1'b1;
                            push_q  = mfs_pkg::PARK_QUEUE;
                        end
                        default: begin
                            // terminate: stack already updated, report the record
                        end
                    endcase
                end

                // queue push: link behind the tail or start the queue
                if (push_en) begin
                    if (r_q_nonempty[push_q]) begin
                        link_we    = 1'b1;
                        link_waddr = r_q_tail[push_q];
                        link_wdata = ex_slot;
                    end else begin
                        n_q_head[push_q] = ex_slot;
                    end
                    n_q_tail[push_q]     = ex_slot;
                    n_q_nonempty[push_q] = 1'b1;
                end
            end

            default: begin
                n_state = mfs_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mfs_pkg::ST_IDLE;
            r_q_nonempty <= '0;
            r_run_slot   <= '0;
            r_run_valid  <= 1'b0;
            r_fresh_cnt  <= '0;
            r_free_top   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_q_nonempty <= n_q_nonempty;
            r_run_slot   <= n_run_slot;
            r_run_valid  <= n_run_valid;
            r_fresh_cnt  <= n_fresh_cnt;
            r_free_top   <= n_free_top;
            r_out_valid  <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_prio       <= n_prio;
        r_elapsed    <= n_elapsed;
        r_slot       <= n_slot;
        r_from_stack <= n_from_stack;
        r_pop_q      <= n_pop_q;
        r_err        <= n_err;
        r_code       <= n_code;
        r_q_head     <= n_q_head;
        r_q_tail     <= n_q_tail;
        r_out_pid    <= n_out_pid;
        r_out_code   <= n_out_code;
        r_out_prio   <= n_out_prio;
        r_out_svc    <= n_out_svc;
        r_out_calls  <= n_out_calls;
    end

endmodule

// ----- tb/sv/mfs_sched_checker.sv -----
// ----------------------------------------------------------------------------
// mfs_sched_checker: response scoreboard for the multilevel feedback scheduler
// Watches both channels, predicts every response from its own copy of the
// task table and queues, and compares each response beat in order.
// ----------------------------------------------------------------------------
module mfs_sched_checker
    import mfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mfs_req_if   i_req,
    mfs_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [CODE_W-1:0]  code;
        logic [LEVEL_W-1:0] level;
        logic [SVC_W-1:0]   svc;
        logic [CALL_W-1:0]  calls;
    } sched_rsp_t;

    // Shadow scheduler state
    logic [SLOT_W-1:0] link_tbl   [MAX_TASKS];
    logic [SLOT_W-1:0] q_head     [NUM_QUEUES];
    logic [SLOT_W-1:0] q_tail     [NUM_QUEUES];
    logic              q_busy     [NUM_QUEUES];
    t_task_rec         task_tbl   [MAX_TASKS];
    logic [SLOT_W-1:0] free_stack [MAX_TASKS];
    logic [CNT_W-1:0]  free_top;
    logic [CNT_W-1:0]  fresh_cnt;
    logic [SLOT_W-1:0] run_slot;
    logic              run_valid;

    sched_rsp_t sched_answers [$];
    sched_rsp_t want;
    sched_rsp_t got;
    int         fails;

    // Append a slot to the tail of a queue
    function automatic void push_queue(input int q, input logic [SLOT_W-1:0] s);
        if (q_busy[q]) link_tbl[q_tail[q]] = s;
        else           q_head[q] = s;
        q_tail[q] = s;
        q_busy[q] = 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] pop_queue(input int q);
        logic [SLOT_W-1:0] s;
        s = q_head[q];
        if (s == q_tail[q]) q_busy[q] = 1'b0;
        else                q_head[q] = link_tbl[s];
        return s;
    endfunction

    function automatic sched_rsp_t error_rsp(input t_result code);
        sched_rsp_t r;
        r = '0;
        r.code = code;
        return r;
    endfunction

    function automatic sched_rsp_t task_rsp(input logic [SLOT_W-1:0] s);
        sched_rsp_t r;
        r.pid   = PID_W'(s) + PID_W'(1);
        r.code  = RES_OK;
        r.level = task_tbl[s].current;
        r.svc   = task_tbl[s].service;
        r.calls = task_tbl[s].calls;
        return r;
    endfunction

    // Apply one request to the shadow state and return the response it earns
    function automatic sched_rsp_t run_sched_op(input logic [OP_W-1:0]      op,
                                                input logic [LEVEL_W-1:0]   prio,
                                                input logic [ELAPSED_W-1:0] elapsed);
        logic [SLOT_W-1:0] s;
        logic [SVC_W:0]    svc_sum;
        logic              hit;
        sched_rsp_t        r;
        r = error_rsp(RES_OK);
        case (op)
            OP_CREATE: begin
                if (free_top != 0) begin
                    free_top = free_top - 1'b1;
                    s = free_stack[free_top[SLOT_W-1:0]];
                end else if (fresh_cnt < MAX_TASKS) begin
                    s = fresh_cnt[SLOT_W-1:0];
                    fresh_cnt = fresh_cnt + 1'b1;
                end else begin
                    return error_rsp(RES_FULL);
                end
                task_tbl[s] = '{desired: prio, current: prio, service: '0, calls: '0};
                push_queue(int'(prio), s);
                r = task_rsp(s);
            end
            OP_DISPATCH: begin
                if (run_valid) begin
                    r = error_rsp(RES_RUNNING);
                end else begin
                    r = error_rsp(RES_NONE);
                    hit = 1'b0;
                    // level 0 wins
                    for (int q = 0; q < NUM_LEVELS; q++) begin
                        if (!hit && q_busy[q]) begin
                            hit = 1'b1;
                            s = pop_queue(q);
                            run_slot = s;
                            run_valid = 1'b1;
                            r = task_rsp(s);
                        end
                    end
                end
            end
            OP_SLICE_END, OP_WAIT, OP_TERMINATE: begin
                if (!run_valid) begin
                    r = error_rsp(RES_NONE);
                end else begin
                    s = run_slot;
                    run_valid = 1'b0;
                    if (op == OP_SLICE_END) begin
                        svc_sum = {1'b0, task_tbl[s].service} + elapsed;
                        task_tbl[s].service = svc_sum[SVC_W] ? '1 : svc_sum[SVC_W-1:0];
                        if (task_tbl[s].calls != '1)
                            task_tbl[s].calls = task_tbl[s].calls + 1'b1;
                        // demote, lowest level wraps back to the desired one
                        if (task_tbl[s].current == LOWEST_LEVEL)
                            task_tbl[s].current = task_tbl[s].desired;
                        else
                            task_tbl[s].current = task_tbl[s].current + 1'b1;
                        push_queue(int'(task_tbl[s].current), s);
                    end else if (op == OP_WAIT) begin
                        push_queue(int'(PARK_QUEUE), s);
                    end else begin
                        free_stack[free_top[SLOT_W-1:0]] = s;
                        if (free_top < MAX_TASKS) free_top = free_top + 1'b1;
                    end
                    r = task_rsp(s);
                end
            end
            default: r = error_rsp(RES_OK);
        endcase
        return r;
    endfunction

    // Score response beats, then log request beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                link_tbl[i]   = '0;
                task_tbl[i]   = '0;
                free_stack[i] = '0;
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
                q_head[i] = '0;
                q_tail[i] = '0;
                q_busy[i] = 1'b0;
            end
            free_top  = '0;
            fresh_cnt = '0;
            run_slot  = '0;
            run_valid = 1'b0;
            fails     = 0;
            sched_answers.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{pid: i_rsp.task_pid, code: i_rsp.result_code,
                        level: i_rsp.task_priority, svc: i_rsp.total_service_ms,
                        calls: i_rsp.slice_count};
                if (sched_answers.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("[%0t] unexpected response beat: pid %0d code %0d",
                                 $realtime, got.pid, got.code);
                end else begin
                    want = sched_answers.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display({"[%0t] mismatch exp pid %0d code %0d lvl %0d",
                                      " svc %0d calls %0d"},
                                     $realtime, want.pid, want.code, want.level, want.svc,
                                     want.calls);
                            $display("           got pid %0d code %0d lvl %0d svc %0d calls %0d",
                                     got.pid, got.code, got.level, got.svc, got.calls);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                sched_answers.push_back(run_sched_op(i_req.op, i_req.priority_req,
                                                     i_req.elapsed_ms));
            o_fail_count <= fails;
            o_pending    <= sched_answers.size();
        end
    end

endmodule

// ----- tb/sv/tb_multilevel_feedback_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_task_scheduler_unit: scheduler testbench top
// Drives directed and episodic random request traffic with varied stalls on
// both channels, a slice run that walks the level wrap with large elapsed
// times, and reports the verdict from the scoreboard's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_task_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mfs_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int PHASE_ITEMS = ITEM_TARGET / 3;
    localparam int WRAP_SLICES = 12;
    localparam int FILL_BURST  = MAX_TASKS + 2;
    localparam int DRAIN_PAIRS = MAX_TASKS + 2;
    localparam int WAIT_BUDGET = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [OP_W-1:0]      OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0]      OP_UNDEF_HI = 3'd7;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MIN = '0;

    logic i_clk;
    logic i_rst_n;

    mfs_req_if req_ch ();
    mfs_rsp_if rsp_ch ();

    int chk_fails;
    int chk_pending;

    int snd_idle_pct = 37;
    int rcv_idle_pct = 86;
    bit snd_calm     = 1'b0;
    bit rcv_calm     = 1'b0;
    int rcv_calm_left = 0;
    int wait_left    = WAIT_BUDGET;
    int n_items      = 0;
    int n_rsp        = 0;
    int stall_cnt    = 0;
    int op_hits [8]  = '{default: 0};

    multilevel_feedback_task_scheduler_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mfs_sched_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Response ready: random stalls with calm stretches
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rcv_calm_left == 0) begin
                rcv_calm      = ($urandom_range(0, 3) == 0);
                rcv_calm_left = $urandom_range(16, 96);
            end else begin
                rcv_calm_left--;
            end
            rsp_ch.ready <= rcv_calm || ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Watchdog on beat activity; also counts response beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) n_rsp++;
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
                if (stall_cnt >= STALL_LIMIT) begin
                    $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // One request beat, with an optional idle gap ahead of it
    task automatic issue_request(input logic [OP_W-1:0]      op,
                                 input logic [LEVEL_W-1:0]   prio,
                                 input logic [ELAPSED_W-1:0] elapsed);
        while (!snd_calm && $urandom_range(0, 99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.priority_req <= prio;
        req_ch.elapsed_ms   <= elapsed;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        op_hits[op]++;
        if (op <= OP_TERMINATE) n_items++;
    endtask

    // Hold off until every outstanding response has been taken
    task automatic settle_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [ELAPSED_W-1:0] rand_elapsed();
        case ($urandom_range(0, 3))
            0:       return ELAPSED_MIN;
            1:       return ELAPSED_MAX;
            2:       return ELAPSED_W'($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_level();
        return LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
    endfunction

    // Blind drain: each pair pops the next ready task, if any, and frees it
    task automatic drain_tasks(input int pairs);
        repeat (pairs) begin
            issue_request(OP_DISPATCH, rand_level(), rand_elapsed());
            issue_request(OP_TERMINATE, rand_level(), rand_elapsed());
        end
    endtask

    // Episodes of mostly well-formed task lifecycles plus noise
    task automatic run_random_phase(input int quota);
        int               start;
        int               n;
        logic [OP_W-1:0]  op;
        start = n_items;
        while (n_items - start < quota) begin
            snd_calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    n = $urandom_range(1, 5);
                    repeat (n) begin
                        issue_request(OP_DISPATCH, rand_level(), rand_elapsed());
                        issue_request(OP_SLICE_END, rand_level(), rand_elapsed());
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        issue_request(OP_DISPATCH, rand_level(), rand_elapsed());
                        if (wait_left > 0 && $urandom_range(0, 7) == 0) begin
                            wait_left--;
                            issue_request(OP_WAIT, rand_level(), rand_elapsed());
                        end else begin
                            issue_request(OP_TERMINATE, rand_level(), rand_elapsed());
                        end
                    end
                end
                4, 5: begin
                    repeat ($urandom_range(1, 4))
                        issue_request(OP_CREATE, rand_level(), rand_elapsed());
                end
                6: drain_tasks($urandom_range(2, 8));
                7, 8: begin
                    repeat ($urandom_range(1, 4)) begin
                        op = OP_W'($urandom_range(0, 7));
                        if (op == OP_WAIT) begin
                            if (wait_left > 0) wait_left--;
                            else op = OP_DISPATCH;
                        end
                        issue_request(op, rand_level(), rand_elapsed());
                    end
                end
                default: begin
                    // overfill the table, then often empty it again
                    repeat (FILL_BURST)
                        issue_request(OP_CREATE, rand_level(), rand_elapsed());
                    if ($urandom_range(0, 1) == 1) drain_tasks(DRAIN_PAIRS);
                end
            endcase
        end
        snd_calm = 1'b0;
    endtask

    // Main sequence
    initial begin
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_CREATE;
        req_ch.priority_req = '0;
        req_ch.elapsed_ms   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: errors on an empty scheduler, undefined ops, every level,
        // demotion, parking, pid reuse; ends with only the parked task left
        issue_request(OP_DISPATCH,  2'd0, ELAPSED_MIN);
        issue_request(OP_SLICE_END, 2'd0, ELAPSED_MAX);
        issue_request(OP_WAIT,      2'd0, ELAPSED_MIN);
        issue_request(OP_TERMINATE, 2'd0, ELAPSED_MIN);
        issue_request(OP_UNDEF_LO,  2'd3, ELAPSED_MAX);
        issue_request(OP_UNDEF_HI,  2'd3, ELAPSED_MAX);
        issue_request(OP_CREATE,    2'd3, ELAPSED_MIN);
        issue_request(OP_CREATE,    2'd0, ELAPSED_MIN);
        issue_request(OP_CREATE,    2'd1, ELAPSED_MIN);
        issue_request(OP_CREATE,    2'd2, ELAPSED_MIN);
        issue_request(OP_DISPATCH,  2'd0, ELAPSED_MIN);
        issue_request(OP_DISPATCH,  2'd0, ELAPSED_MIN);
        issue_request(OP_SLICE_END, 2'd0, ELAPSED_MAX);
        issue_request(OP_DISPATCH,  2'd0, ELAPSED_MIN);
        issue_request(OP_WAIT,      2'd0, ELAPSED_MIN);
        issue_request(OP_DISPATCH,  2'd0, ELAPSED_MIN);
        issue_request(OP_TERMINATE, 2'd0, ELAPSED_MIN);
        issue_request(OP_CREATE,    2'd0, ELAPSED_MIN);
        issue_request(OP_DISPATCH,  2'd0, ELAPSED_MIN);
        issue_request(OP_SLICE_END, 2'd0, ELAPSED_MIN);
        drain_tasks(3);
        settle_responses();

        // Random, sender light and receiver heavy on stalls
        run_random_phase(PHASE_ITEMS);
        settle_responses();

        // Random, stall ratios swapped
        snd_idle_pct = 86;
        rcv_idle_pct <= 37;
        run_random_phase(PHASE_ITEMS);
        settle_responses();

        // No stalls: one lone task sliced with large elapsed times,
        // walking the level wrap several times
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        drain_tasks(DRAIN_PAIRS);
        issue_request(OP_CREATE, 2'd1, ELAPSED_MIN);
        repeat (WRAP_SLICES) begin
            issue_request(OP_DISPATCH, 2'd1, ELAPSED_MIN);
            issue_request(OP_SLICE_END, 2'd1, ELAPSED_MAX);
        end
        issue_request(OP_DISPATCH, 2'd1, ELAPSED_MIN);
        issue_request(OP_TERMINATE, 2'd1, ELAPSED_MIN);
        run_random_phase(ITEM_TARGET - 2 * PHASE_ITEMS);

        settle_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display({"Run: %0d requests (create %0d, dispatch %0d, slice %0d,",
                  " wait %0d, kill %0d, undef %0d)"},
                 n_items + op_hits[5] + op_hits[6] + op_hits[7],
                 op_hits[OP_CREATE], op_hits[OP_DISPATCH], op_hits[OP_SLICE_END],
                 op_hits[OP_WAIT], op_hits[OP_TERMINATE],
                 op_hits[5] + op_hits[6] + op_hits[7]);
        $display("Scored %0d responses incl. full-table sweeps, pid reuse and level wraps",
                 n_rsp);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mfs_pkg.sv
rtl/mfs_ifs.sv
rtl/mfs_ram.sv
rtl/multilevel_feedback_task_scheduler_unit.sv
tb/sv/mfs_sched_checker.sv
tb/sv/tb_multilevel_feedback_task_scheduler_unit.sv
